// ===== rtl/core/msc_dgf_pkg.sv =====
package msc_dgf_pkg;

	// sequencer position inside one queued entry
	typedef enum logic [3:0] {
		STEP_HDR_FIRST = 4'd0,
		STEP_HDR_1     = 4'd1,
		STEP_HDR_2     = 4'd2,
		STEP_HDR_3     = 4'd3,
		STEP_HDR_4     = 4'd4,
		STEP_HDR_5     = 4'd5,
		STEP_HDR_6     = 4'd6,
		STEP_HDR_7     = 4'd7,
		STEP_HDR_LAST  = 4'd8,
		STEP_DATA      = 4'd9,
		STEP_CRC_HI    = 4'd10,
		STEP_CRC_LO    = 4'd11
	} step_t;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	// ext 0, crc 1, segment 1, user access 1
	localparam logic [3:0]  HDR_FLAGS  = 4'h7;
	// rfa 0, transport id flag 1, length 2
	localparam logic [7:0]  HDR_UA     = 8'h12;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start;
		logic        has_data;
		logic        close;
		logic [3:0]  group_type;
		logic [14:0] segment_number;
		logic        last_segment;
		logic [15:0] transport_id;
		logic [12:0] segment_length;
	} entry_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/msc_dgf_ifs.sv =====
interface msc_dgf_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        group_start;
	logic [3:0]  group_type;
	logic [14:0] segment_number;
	logic        last_segment;
	logic [15:0] transport_id;
	logic [12:0] segment_length;

	modport source (
		output valid, data_byte, group_start, group_type, segment_number,
			last_segment, transport_id, segment_length,
		input ready
	);
	modport sink (
		input valid, data_byte, group_start, group_type, segment_number,
			last_segment, transport_id, segment_length,
		output ready
	);
endinterface

interface msc_dgf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_group;

	modport source (output valid, out_byte, end_of_group, input ready);
	modport sink (input valid, out_byte, end_of_group, output ready);
endinterface

// ===== rtl/core/msc_dgf_front.sv =====
module msc_dgf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	msc_dgf_in_if.sink           payload,
	input  logic                 q_ready,
	output logic                 push,
	output msc_dgf_pkg::entry_t  entry
);

	logic        open_q;
	logic [12:0] remaining_q;
	logic        accept;
	logic [12:0] rem_next;
	logic        len_zero;

	assign payload.ready = q_ready;
	assign accept        = payload.valid && payload.ready;
	assign len_zero      = (payload.segment_length == 13'd0);

	always_comb begin
		if (payload.group_start) begin
			rem_next = payload.segment_length - 13'd1;
		end else begin
			rem_next = remaining_q - 13'd1;
		end
	end

	// words outside a group are dropped here
	assign push = accept && (payload.group_start || open_q);

	always_comb begin
		entry.data_byte      = payload.data_byte;
		entry.start          = payload.group_start;
		entry.has_data       = !(payload.group_start && len_zero);
		entry.close          = (payload.group_start && len_zero) || (rem_next == 13'd0);
		entry.group_type     = payload.group_type;
		entry.segment_number = payload.segment_number;
		entry.last_segment   = payload.last_segment;
		entry.transport_id   = payload.transport_id;
		entry.segment_length = payload.segment_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			remaining_q <= '0;
		end else if (push) begin
			if (entry.close) begin
				open_q      <= 1'b0;
				remaining_q <= '0;
			end else begin
				open_q      <= 1'b1;
				remaining_q <= rem_next;
			end
		end
	end

endmodule

// ===== rtl/core/msc_dgf_fifo.sv =====
module msc_dgf_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  msc_dgf_pkg::entry_t  wr_entry,
	output logic                 wr_ready,
	output logic                 rd_valid,
	output msc_dgf_pkg::entry_t  rd_entry,
	input  logic                 pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	msc_dgf_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign wr_ready = (count_q != CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rptr_q];
	assign do_push  = push && wr_ready;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/msc_dgf_back.sv =====
module msc_dgf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  msc_dgf_pkg::entry_t  q_entry,
	output logic                 q_pop,
	msc_dgf_out_if.source        framed
);

	msc_dgf_pkg::step_t step_q;
	msc_dgf_pkg::step_t cur_step;
	msc_dgf_pkg::step_t next_step;
	logic        first_q;
	logic        done;
	logic        fire;
	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [15:0] crc_inv;
	logic [7:0]  byte_sel;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        eog_q;

	assign framed.valid        = valid_q;
	assign framed.out_byte     = byte_q;
	assign framed.end_of_group = eog_q;

	assign fire     = q_valid && (!valid_q || framed.ready);
	assign cur_step = first_q ? (q_entry.start ? msc_dgf_pkg::STEP_HDR_FIRST
		: msc_dgf_pkg::STEP_DATA) : step_q;
	assign crc_base = (cur_step == msc_dgf_pkg::STEP_HDR_FIRST) ? msc_dgf_pkg::CRC_INIT : crc_q;
	assign crc_inv  = ~crc_q;

	always_comb begin
		done      = 1'b0;
		next_step = msc_dgf_pkg::step_t'(cur_step + 4'd1);
		case (cur_step)
			msc_dgf_pkg::STEP_HDR_LAST: begin
				next_step = q_entry.has_data ? msc_dgf_pkg::STEP_DATA : msc_dgf_pkg::STEP_CRC_HI;
			end
			msc_dgf_pkg::STEP_DATA: begin
				next_step = msc_dgf_pkg::STEP_CRC_HI;
				done      = !q_entry.close;
			end
			msc_dgf_pkg::STEP_CRC_LO: begin
				done = 1'b1;
			end
			default: begin
				next_step = msc_dgf_pkg::step_t'(cur_step + 4'd1);
			end
		endcase
	end

	always_comb begin
		case (cur_step)
			msc_dgf_pkg::STEP_HDR_FIRST: byte_sel = {msc_dgf_pkg::HDR_FLAGS, q_entry.group_type};
			msc_dgf_pkg::STEP_HDR_1:     byte_sel = {q_entry.segment_number[3:0], 4'h0};
			msc_dgf_pkg::STEP_HDR_2:     byte_sel = {q_entry.last_segment,
				q_entry.segment_number[14:8]};
			msc_dgf_pkg::STEP_HDR_3:     byte_sel = q_entry.segment_number[7:0];
			msc_dgf_pkg::STEP_HDR_4:     byte_sel = msc_dgf_pkg::HDR_UA;
			msc_dgf_pkg::STEP_HDR_5:     byte_sel = q_entry.transport_id[15:8];
			msc_dgf_pkg::STEP_HDR_6:     byte_sel = q_entry.transport_id[7:0];
			msc_dgf_pkg::STEP_HDR_7:     byte_sel = {3'b000, q_entry.segment_length[12:8]};
			msc_dgf_pkg::STEP_HDR_LAST:  byte_sel = q_entry.segment_length[7:0];
			msc_dgf_pkg::STEP_DATA:      byte_sel = q_entry.data_byte;
			msc_dgf_pkg::STEP_CRC_HI:    byte_sel = crc_inv[15:8];
			msc_dgf_pkg::STEP_CRC_LO:    byte_sel = crc_inv[7:0];
			default:                     byte_sel = q_entry.data_byte;
		endcase
	end

	assign q_pop = fire && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			step_q  <= msc_dgf_pkg::STEP_HDR_FIRST;
			crc_q   <= msc_dgf_pkg::CRC_INIT;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				first_q <= done;
				step_q  <= next_step;
				valid_q <= 1'b1;
				if (cur_step <= msc_dgf_pkg::STEP_DATA) begin
					crc_q <= msc_dgf_pkg::crc_step(crc_base, byte_sel);
				end
			end else if (framed.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= byte_sel;
			eog_q  <= (cur_step == msc_dgf_pkg::STEP_CRC_LO);
		end
	end

endmodule

// ===== rtl/core/msc_data_group_framer_core.sv =====
// MSC data group framer. Payload words enter on "payload"; a word with
// group_start set opens a group, samples the header fields and is framed as a
// 9-byte header followed by that byte, unless segment_length is zero. Later
// words pass through one per cycle while the queue has room, until segment_length
// bytes have gone by; then the inverted CRC-16-CCITT (header and payload, preset
// FFFF) follows high byte first, end_of_group on the low byte. Words outside a
// group are dropped. The input side takes one word per cycle while the entry
// queue (QUEUE_DEPTH) has room; the output sequencer emits one byte per cycle
// while the sink is ready, so a plain payload word yields one byte, a
// group-opening word ten, and the closing word two more for the CRC.
module msc_data_group_framer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	msc_dgf_in_if.sink    payload,
	msc_dgf_out_if.source framed
);

	logic                push;
	logic                q_ready;
	logic                q_valid;
	logic                q_pop;
	msc_dgf_pkg::entry_t wr_entry;
	msc_dgf_pkg::entry_t rd_entry;

	msc_dgf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.q_ready (q_ready),
		.push    (push),
		.entry   (wr_entry)
	);

	msc_dgf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.wr_ready (q_ready),
		.rd_valid (q_valid),
		.rd_entry (rd_entry),
		.pop      (q_pop)
	);

	msc_dgf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (rd_entry),
		.q_pop   (q_pop),
		.framed  (framed)
	);

`ifndef SYNTHESIS
	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_ready)
		else $error("entry pushed into full queue");

	a_start_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(payload.valid && payload.ready && payload.group_start) |-> push)
		else $error("group start word was dropped");

	a_zero_len_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(push && wr_entry.start && (wr_entry.segment_length == 13'd0))
			|-> (wr_entry.close && !wr_entry.has_data))
		else $error("zero length group not closed at once");
`endif

endmodule

// ===== tb/sv/msc_data_group_framer_core_test.sv =====
module msc_data_group_framer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 400;
	localparam int TARGET_WORDS = 370;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        group_start;
		logic [3:0]  group_type;
		logic [14:0] segment_number;
		logic        last_segment;
		logic [15:0] transport_id;
		logic [12:0] segment_length;
	} dg_word_t;

	typedef struct packed {
		logic [7:0] value;
		logic       eog;
	} framed_byte_t;

	// framer state mirror plus the queue of framed bytes still owed
	class framed_byte_board;
		framed_byte_t expected_q[$];
		logic [12:0]  bytes_left;
		logic [15:0]  crc;
		bit           in_group;
		int           failures;
		int           checked;
		int           closed_groups;
		int           cut_groups;
		int           dropped_words;

		function new();
			bytes_left    = '0;
			crc           = msc_dgf_pkg::CRC_INIT;
			in_group      = 1'b0;
			failures      = 0;
			checked       = 0;
			closed_groups = 0;
			cut_groups    = 0;
			dropped_words = 0;
		endfunction

		function void emit(logic [7:0] b, logic eog, bit fold);
			framed_byte_t e;
			e.value = b;
			e.eog   = eog;
			expected_q.push_back(e);
			// bitwise CCITT, MSB first
			if (fold) begin
				for (int i = 7; i >= 0; i--) begin
					crc = {crc[14:0], 1'b0} ^ ((crc[15] ^ b[i]) ? msc_dgf_pkg::CRC_POLY : 16'h0000);
				end
			end
		endfunction

		function void close_group();
			logic [15:0] c;
			c = ~crc;
			emit(c[15:8], 1'b0, 1'b0);
			emit(c[7:0], 1'b1, 1'b0);
			in_group   = 1'b0;
			bytes_left = '0;
			crc        = msc_dgf_pkg::CRC_INIT;
			closed_groups++;
		endfunction

		function void note_word(dg_word_t w);
			if (w.group_start) begin
				if (in_group) begin
					cut_groups++;
				end
				crc      = msc_dgf_pkg::CRC_INIT;
				in_group = 1'b1;
				emit({msc_dgf_pkg::HDR_FLAGS, w.group_type}, 1'b0, 1'b1);
				emit({w.segment_number[3:0], 4'h0}, 1'b0, 1'b1);
				emit({w.last_segment, w.segment_number[14:8]}, 1'b0, 1'b1);
				emit(w.segment_number[7:0], 1'b0, 1'b1);
				emit(msc_dgf_pkg::HDR_UA, 1'b0, 1'b1);
				emit(w.transport_id[15:8], 1'b0, 1'b1);
				emit(w.transport_id[7:0], 1'b0, 1'b1);
				emit({3'b000, w.segment_length[12:8]}, 1'b0, 1'b1);
				emit(w.segment_length[7:0], 1'b0, 1'b1);
				if (w.segment_length == '0) begin
					close_group();
					return;
				end
				bytes_left = w.segment_length;
			end else if (!in_group) begin
				dropped_words++;
				return;
			end
			emit(w.data_byte, 1'b0, 1'b1);
			bytes_left = bytes_left - 13'd1;
			if (bytes_left == '0) begin
				close_group();
			end
		endfunction

		function void check_byte(logic [7:0] b, logic eog);
			framed_byte_t e;
			checked++;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("unexpected framed word: byte %02h eog %b", b, eog);
				end
				return;
			end
			e = expected_q.pop_front();
			if (b !== e.value || eog !== e.eog) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("framed word %0d: expected byte %02h eog %b, got byte %02h eog %b",
						checked, e.value, e.eog, b, eog);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	msc_dgf_in_if  payload();
	msc_dgf_out_if framed();

	msc_data_group_framer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.payload(payload),
		.framed (framed)
	);

	framed_byte_board board = new();

	bit steady_src    = 1'b0;
	bit steady_sink   = 1'b0;
	bit long_hold_req = 1'b0;
	int words_sent    = 0;
	int cycle_count   = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (payload.valid && payload.ready) begin
				board.note_word({payload.data_byte, payload.group_start, payload.group_type,
					payload.segment_number, payload.last_segment, payload.transport_id,
					payload.segment_length});
			end
			if (framed.valid && framed.ready) begin
				board.check_byte(framed.out_byte, framed.end_of_group);
			end
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic dg_word_t rand_word(bit start, logic [12:0] len);
		dg_word_t w;
		w.data_byte      = 8'($urandom);
		w.group_start    = start;
		w.group_type     = 4'($urandom);
		w.segment_number = 15'($urandom);
		w.last_segment   = 1'($urandom);
		w.transport_id   = 16'($urandom);
		w.segment_length = start ? len : 13'($urandom);
		return w;
	endfunction

	function automatic dg_word_t make_head(logic [3:0] gtype, logic [14:0] segnum, logic last,
		logic [15:0] tid, logic [12:0] len, logic [7:0] data);
		dg_word_t w;
		w.data_byte      = data;
		w.group_start    = 1'b1;
		w.group_type     = gtype;
		w.segment_number = segnum;
		w.last_segment   = last;
		w.transport_id   = tid;
		w.segment_length = len;
		return w;
	endfunction

	task automatic send_word(input dg_word_t w);
		payload.valid          <= 1'b1;
		payload.data_byte      <= w.data_byte;
		payload.group_start    <= w.group_start;
		payload.group_type     <= w.group_type;
		payload.segment_number <= w.segment_number;
		payload.last_segment   <= w.last_segment;
		payload.transport_id   <= w.transport_id;
		payload.segment_length <= w.segment_length;
		do @(posedge clk); while (payload.ready !== 1'b1);
	endtask

	task automatic idle_a_bit();
		if (!steady_src && $urandom_range(0, 3) == 0) begin
			payload.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// count < segment_length leaves the group open for the next start to cut
	task automatic send_group(input dg_word_t head, input int count);
		send_word(head);
		idle_a_bit();
		for (int k = 1; k < count; k++) begin
			send_word(rand_word(1'b0, '0));
			idle_a_bit();
		end
		words_sent += count;
	endtask

	task automatic send_stray(input logic [7:0] data);
		dg_word_t w;
		w = rand_word(1'b0, '0);
		w.data_byte = data;
		send_word(w);
		idle_a_bit();
	endtask

	// sink side: random stalls, one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		framed.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (long_hold_req) begin
					stall_left    = LONG_HOLD;
					long_hold_req = 1'b0;
				end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
					stall_left = gap_len();
				end
			end
			if (stall_left > 0) begin
				framed.ready <= 1'b0;
				stall_left--;
			end else begin
				framed.ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d framed words outstanding",
			cycle_count, board.pending());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		bit group_is_open;
		bit pressure_done;
		bit pause_done;
		int len;
		int count;
		int pick;

		group_is_open = 1'b0;
		pressure_done = 1'b0;
		pause_done    = 1'b0;
		arst_n                 <= 1'b0;
		payload.valid          <= 1'b0;
		payload.data_byte      <= '0;
		payload.group_start    <= 1'b0;
		payload.group_type     <= '0;
		payload.segment_number <= '0;
		payload.last_segment   <= 1'b0;
		payload.transport_id   <= '0;
		payload.segment_length <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: strays, one-byte groups at field extremes, cut groups
		send_stray(8'hFF);
		send_group(make_head(4'hF, 15'h7FFF, 1'b1, 16'hFFFF, 13'd1, 8'hFF), 1);
		send_group(make_head(4'h0, 15'h0000, 1'b0, 16'h0000, 13'd1, 8'h00), 1);
		send_stray(8'h00);
		send_group(make_head(4'd3, 15'h2A5A, 1'b0, 16'h1234, 13'd3, 8'h80), 3);
		send_group(make_head(4'd4, 15'h55A5, 1'b1, 16'h8001, 13'h1FFF, 8'h7F), 3);
		send_group(make_head(4'd4, 15'h000F, 1'b0, 16'hFF00, 13'd2, 8'h01), 2);
		send_group(make_head(4'hF, 15'h7FF0, 1'b0, 16'h00FF, 13'h1E00, 8'hC3), 2);
		send_group(make_head(4'h8, 15'h0010, 1'b1, 16'h5A5A, 13'd4, 8'h3C), 4);

		while (words_sent < TARGET_WORDS) begin
			if ($urandom_range(0, 5) == 0) begin
				steady_src  = 1'($urandom_range(0, 1));
				steady_sink = 1'($urandom_range(0, 1));
			end
			if (!pressure_done && words_sent > 120) begin
				// sink holds off while source streams back to back
				long_hold_req = 1'b1;
				steady_src    = 1'b1;
				send_group(rand_word(1'b1, 13'd40), 40);
				steady_src    = 1'b0;
				pressure_done = 1'b1;
				group_is_open = 1'b0;
				continue;
			end
			if (!pause_done && words_sent > 240 && !group_is_open) begin
				payload.valid <= 1'b0;
				do @(posedge clk); while (board.pending() != 0);
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 6 && !group_is_open) begin
				send_stray(8'($urandom));
				continue;
			end
			if (pick < 9) begin
				len = $urandom_range(1, 8191);
			end else if (pick < 15) begin
				len = $urandom_range(41, 120);
			end else if (pick < 35) begin
				len = $urandom_range(9, 40);
			end else begin
				len = $urandom_range(1, 8);
			end
			count = len;
			if (pick < 9 && len > 6) begin
				count = $urandom_range(1, 6);
			end else if (len > 1 && $urandom_range(0, 9) == 0) begin
				count = $urandom_range(1, len - 1);
			end
			send_group(rand_word(1'b1, 13'(len)), count);
			group_is_open = (count < len);
		end

		payload.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d closed groups, %0d cut short by a new start, %0d stray words dropped",
			board.closed_groups, board.cut_groups, board.dropped_words);
		$display("%0d framed words checked, %0d failures, %0d still outstanding",
			board.checked, board.failures, board.pending());
		if (board.failures == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/msc_dgf_pkg.sv
rtl/core/msc_dgf_ifs.sv
rtl/core/msc_dgf_front.sv
rtl/core/msc_dgf_fifo.sv
rtl/core/msc_dgf_back.sv
rtl/core/msc_data_group_framer_core.sv
tb/sv/msc_data_group_framer_core_test.sv
